// File: src/bvl_pkg.sv
// package: shared codes, field widths and cell control types for the value list
`timescale 1ns / 1ps

package bvl_pkg;

  localparam int REQ_W       = 2;
  localparam int VALUE_IN_W  = 32;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int POS_OUT_W   = 6;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_FIND   = 2'd2,
    OP_ERASE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic active;
    logic found;
    logic rd_hit;
  } wave_ctl_t;

endpackage

// File: src/bvl_cell.sv
// list cell: one stored entry plus the registered stage of the request wave
`timescale 1ns / 1ps

module bvl_cell import bvl_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int POS_WIDTH   = 6,
  parameter int COUNT_WIDTH = 7,
  parameter int CELL_POS    = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  op_t                    op,
  input  logic [VALUE_WIDTH-1:0] val,
  input  logic [INDEX_W-1:0]     index,
  input  logic [COUNT_WIDTH-1:0] count,
  input  wave_ctl_t              ctl_in,
  input  logic [POS_WIDTH-1:0]   pos_in,
  input  logic [VALUE_WIDTH-1:0] data_in,
  input  logic [VALUE_WIDTH-1:0] next_entry,
  output wave_ctl_t              ctl_out,
  output logic [POS_WIDTH-1:0]   pos_out,
  output logic [VALUE_WIDTH-1:0] data_out,
  output logic [VALUE_WIDTH-1:0] entry
);

  localparam bit IDX_REACH = (CELL_POS < (1 << INDEX_W));

  logic in_list;
  logic at_end;
  logic has_next;
  logic idx_hit;
  logic match;
  logic rd_here;

  assign in_list  = COUNT_WIDTH'(CELL_POS) < count;
  assign at_end   = COUNT_WIDTH'(CELL_POS) == count;
  assign has_next = COUNT_WIDTH'(CELL_POS + 1) < count;
  assign idx_hit  = IDX_REACH && (index == INDEX_W'(CELL_POS));
  assign match    = in_list && !ctl_in.found && (entry == val) &&
                    ((op == OP_FIND) || (op == OP_ERASE));
  assign rd_here  = (op == OP_READ) && in_list && idx_hit;

  // entry storage: append at the tail, close the gap on erase
  always_ff @(posedge clk) begin
    if (ctl_in.active) begin
      if ((op == OP_APPEND) && at_end) begin
        entry <= val;
      end else if ((op == OP_ERASE) && (ctl_in.found || match) && has_next) begin
        entry <= next_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.active <= ctl_in.active;
      ctl_out.found  <= ctl_in.found || match;
      ctl_out.rd_hit <= ctl_in.rd_hit || rd_here;
    end
  end

  always_ff @(posedge clk) begin
    pos_out  <= match ? POS_WIDTH'(CELL_POS) : pos_in;
    data_out <= rd_here ? entry : data_in;
  end

endmodule

// File: src/bounded_value_list_unit.sv
// top level: bounded value list built as a chain of entry cells
`timescale 1ns / 1ps

// usage
// - input channel in_valid/in_ready carries req_type, value and index; one
//   request is in flight at a time, in_ready is high whenever none is
// - a request travels down the chain of CAPACITY cells, one cell per cycle;
//   each cell compares, captures or shifts its own entry as the request passes
// - output channel out_valid/out_ready carries status, position, read_value
//   and entry_count from a result register
// - out_valid rises once the request has passed the head register, every cell
//   and the tail register; a new request is taken once the previous result
//   has entered the result register: every request visits each cell
// - a stalled receiver holds the result register; the next request is still
//   taken, and its finished result waits at the end of the chain until the
//   result register is free
// - reset (rst, synchronous) empties the list and drops any request in flight;
//   stored entries are not cleared, only the entry count

module bounded_value_list_unit import bvl_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [REQ_W-1:0]             req_type,
  input  logic signed [VALUE_IN_W-1:0] value,
  input  logic [INDEX_W-1:0]           index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_W-1:0]          status,
  output logic [POS_OUT_W-1:0]         position,
  output logic signed [VALUE_IN_W-1:0] read_value,
  output logic [COUNT_OUT_W-1:0]       entry_count
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                   busy;
  logic                   pend;
  op_t                    req_op;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [INDEX_W-1:0]     req_index;
  logic [CW-1:0]          count;

  wave_ctl_t              ctl  [0:CAPACITY];
  logic [PW-1:0]          pos  [0:CAPACITY];
  logic [VALUE_WIDTH-1:0] data [0:CAPACITY];
  logic [VALUE_WIDTH-1:0] entry [0:CAPACITY-1];
  logic [CAPACITY:0]      wave_act;

  wave_ctl_t              res_ctl;
  logic [PW-1:0]          res_pos;
  logic [VALUE_WIDTH-1:0] res_data;

  logic                   in_xfer;
  logic                   finish;
  logic [63:0]            val_ext;
  status_t                res_status;
  logic [PW-1:0]          res_position;
  logic [VALUE_WIDTH-1:0] res_read;
  logic [CW-1:0]          count_next;
  logic [PW+POS_OUT_W-1:0]       pos_wide;
  logic [CW+COUNT_OUT_W-1:0]     count_wide;
  logic [VALUE_WIDTH+VALUE_IN_W-1:0] rd_wide;

  assign in_ready = !busy;
  assign in_xfer  = in_valid && in_ready;
  assign finish   = pend && (!out_valid || out_ready);
  assign val_ext  = {{(64 - VALUE_IN_W){value[VALUE_IN_W-1]}}, value};

  // request registers, held for the whole pass
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op    <= op_t'(req_type);
      req_val   <= val_ext[VALUE_WIDTH-1:0];
      req_index <= index;
    end
  end

  // head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].active <= in_xfer;
      ctl[0].found  <= 1'b0;
      ctl[0].rd_hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos[0]  <= '0;
    data[0] <= '0;
  end

  assign wave_act[0] = ctl[0].active;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] nxt;

    if (i < CAPACITY - 1) begin : g_mid
      assign nxt = entry[i+1];
    end else begin : g_last
      assign nxt = '0;
    end

    bvl_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .POS_WIDTH   (PW),
      .COUNT_WIDTH (CW),
      .CELL_POS    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (req_op),
      .val        (req_val),
      .index      (req_index),
      .count      (count),
      .ctl_in     (ctl[i]),
      .pos_in     (pos[i]),
      .data_in    (data[i]),
      .next_entry (nxt),
      .ctl_out    (ctl[i+1]),
      .pos_out    (pos[i+1]),
      .data_out   (data[i+1]),
      .entry      (entry[i])
    );

    assign wave_act[i+1] = ctl[i+1].active;
  end

  // tail of the chain: hold the finished pass until the result register frees
  always_ff @(posedge clk) begin
    if (ctl[CAPACITY].active) begin
      res_ctl  <= ctl[CAPACITY];
      res_pos  <= pos[CAPACITY];
      res_data <= data[CAPACITY];
    end
  end

  always_comb begin
    res_status   = ST_OK;
    res_position = '0;
    res_read     = '0;
    count_next   = count;
    case (req_op)
      OP_APPEND: begin
        if (count == CW'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_READ: begin
        if (res_ctl.rd_hit) begin
          res_read = res_data;
        end else begin
          res_status = ST_RANGE;
        end
      end
      OP_FIND: begin
        if (res_ctl.found) begin
          res_position = res_pos;
        end else begin
          res_status = ST_MISSING;
        end
      end
      OP_ERASE: begin
        if (res_ctl.found) begin
          res_position = res_pos;
          count_next   = count - 1'b1;
        end else begin
          res_status = ST_MISSING;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign pos_wide   = {{POS_OUT_W{1'b0}}, res_position};
  assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};
  assign rd_wide    = {{VALUE_IN_W{1'b0}}, res_read};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (ctl[CAPACITY].active) begin
        pend <= 1'b1;
      end else if (finish) begin
        pend <= 1'b0;
      end
      if (finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status      <= res_status;
      position    <= pos_wide[POS_OUT_W-1:0];
      read_value  <= rd_wide[VALUE_IN_W-1:0];
      entry_count <= count_wide[COUNT_OUT_W-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_single_wave: assert property (@(posedge clk) disable iff (rst)
    $onehot0({pend, wave_act}))
    else $error("more than one request in the chain");

  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!pend && (wave_act == '0)))
    else $error("ready while a request is still in the chain");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    !$past(finish) && !$past(rst) |-> $stable(count))
    else $error("entry count changed outside a result transfer");
`endif

endmodule

// File: bench/tb_bounded_value_list_unit.sv
// testbench: bounded value list unit checked against a behavioural list model
`timescale 1ns / 1ps

module tb_bounded_value_list_unit;
  import bvl_pkg::*;

  localparam int LIST_CAP = 64;

  typedef struct {
    status_t                       status;
    logic [POS_OUT_W-1:0]          position;
    logic signed [VALUE_IN_W-1:0]  read_value;
    logic [COUNT_OUT_W-1:0]        entry_count;
  } list_reply_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [REQ_W-1:0]             req_type = '0;
  logic signed [VALUE_IN_W-1:0] value = '0;
  logic [INDEX_W-1:0]           index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [STATUS_W-1:0]          status;
  logic [POS_OUT_W-1:0]         position;
  logic signed [VALUE_IN_W-1:0] read_value;
  logic [COUNT_OUT_W-1:0]       entry_count;

  logic signed [VALUE_IN_W-1:0] model_words [LIST_CAP];
  int                           model_len = 0;
  list_reply_t                  replies_due [$];
  int                           errors = 0;
  bit                           calm = 1'b0;
  int                           hold_len = 0;
  int                           hold_left = 0;
  int                           stall_left = 0;

  bounded_value_list_unit #(
    .CAPACITY(LIST_CAP),
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .value(value),
    .index(index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .position(position),
    .read_value(read_value),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic list_reply_t list_apply(op_t op, logic signed [VALUE_IN_W-1:0] v,
                                             logic [INDEX_W-1:0] idx);
    list_reply_t r;
    int hit;
    r.status      = ST_OK;
    r.position    = '0;
    r.read_value  = '0;
    hit = -1;
    for (int i = 0; i < model_len; i++) begin
      if (hit < 0 && model_words[i] == v) hit = i;
    end
    case (op)
      OP_APPEND: begin
        if (model_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          model_words[model_len] = v;
          model_len++;
        end
      end
      OP_READ: begin
        if (idx >= model_len) r.status = ST_RANGE;
        else r.read_value = model_words[idx];
      end
      OP_FIND: begin
        if (hit < 0) r.status = ST_MISSING;
        else r.position = POS_OUT_W'(hit);
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.position = POS_OUT_W'(hit);
          for (int i = hit; i + 1 < model_len; i++) model_words[i] = model_words[i + 1];
          model_len--;
        end
      end
    endcase
    r.entry_count = COUNT_OUT_W'(model_len);
    return r;
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function automatic logic signed [VALUE_IN_W-1:0] pick_value(bit reuse);
    if (reuse && model_len > 0 && $urandom_range(0, 2) != 0)
      return model_words[$urandom_range(0, model_len - 1)];
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (model_len > 0 && $urandom_range(0, 3) != 0)
      return INDEX_W'($urandom_range(0, model_len - 1));
    return INDEX_W'($urandom_range(0, LIST_CAP - 1));
  endfunction

  task automatic issue_request(op_t op, logic signed [VALUE_IN_W-1:0] v,
                               logic [INDEX_W-1:0] idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    value    <= v;
    index    <= idx;
    do @(posedge clk); while (!in_ready);
    replies_due.push_back(list_apply(op, v, idx));
  endtask

  task automatic drain_list();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (LIST_CAP + 8) @(posedge clk);
  endtask

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
    end else if (hold_len != 0) begin
      hold_left <= hold_len;
      hold_len  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side: random stalls (none while calm), checks every transfer
  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                   $time, status, entry_count);
          errors++;
        end else begin
          want = replies_due.pop_front();
          compare_field("status", want.status, status);
          compare_field("position", want.position, position);
          compare_field("read_value", want.read_value, read_value);
          compare_field("entry_count", want.entry_count, entry_count);
        end
        stall_left = calm ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      out_ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  task automatic test_empty_list();
    issue_request(OP_READ, 32'sd0, 6'd0);
    issue_request(OP_FIND, 32'sd0, 6'd63);
    issue_request(OP_ERASE, 32'sd0, 6'd0);
  endtask

  task automatic test_append_and_lookup();
    issue_request(OP_APPEND, 32'sh8000_0000, 6'd0);
    issue_request(OP_APPEND, 32'sh7fff_ffff, 6'd63);
    issue_request(OP_APPEND, 32'sd0, 6'd0);
    issue_request(OP_APPEND, -32'sd1, 6'd0);
    issue_request(OP_APPEND, 32'sh7fff_ffff, 6'd0);
    // duplicate: lowest position wins
    issue_request(OP_FIND, 32'sh7fff_ffff, 6'd0);
    issue_request(OP_FIND, -32'sd1, 6'd0);
    issue_request(OP_FIND, 32'sd12345, 6'd0);
    issue_request(OP_READ, 32'sd0, 6'd0);
    issue_request(OP_READ, 32'sd0, 6'd4);
    issue_request(OP_READ, 32'sd0, 6'd5);
    issue_request(OP_READ, 32'sd0, 6'd63);
  endtask

  task automatic test_erase_shifts();
    issue_request(OP_ERASE, 32'sh7fff_ffff, 6'd0);
    issue_request(OP_READ, 32'sd0, 6'd1);
    issue_request(OP_FIND, 32'sh7fff_ffff, 6'd0);
    issue_request(OP_ERASE, 32'sh8000_0000, 6'd0);
    issue_request(OP_ERASE, 32'sd99, 6'd0);
    issue_request(OP_ERASE, -32'sd1, 6'd0);
  endtask

  task automatic test_fill_to_capacity();
    while (model_len < LIST_CAP) issue_request(OP_APPEND, pick_value(1'b0), pick_index());
    issue_request(OP_APPEND, 32'sh8000_0000, 6'd0);
    issue_request(OP_APPEND, 32'sh7fff_ffff, 6'd63);
    issue_request(OP_READ, 32'sd0, 6'd63);
    issue_request(OP_FIND, model_words[LIST_CAP - 1], 6'd0);
    issue_request(OP_ERASE, model_words[$urandom_range(0, LIST_CAP - 2)], 6'd0);
    issue_request(OP_READ, 32'sd0, 6'd63);
    issue_request(OP_APPEND, -32'sd1, 6'd0);
    issue_request(OP_APPEND, 32'sd0, 6'd0);
  endtask

  task automatic test_input_backpressure();
    calm     <= 1'b1;
    hold_len <= 400;
    repeat (24) begin
      if ($urandom_range(0, 1) != 0) issue_request(OP_ERASE, pick_value(1'b1), pick_index());
      else issue_request(OP_READ, pick_value(1'b1), pick_index());
    end
    drain_list();
    calm <= 1'b0;
  endtask

  task automatic test_random_traffic(int items);
    int regime;
    int r;
    op_t op;
    regime = 2;
    for (int n = 0; n < items; n++) begin
      if (n % 100 == 0) begin
        regime = $urandom_range(0, 2);
        calm <= ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      case (regime)
        0: op = (r < 60) ? OP_APPEND : (r < 75) ? OP_READ : (r < 90) ? OP_FIND : OP_ERASE;
        1: op = (r < 15) ? OP_APPEND : (r < 30) ? OP_READ : (r < 50) ? OP_FIND : OP_ERASE;
        default: op = (r < 30) ? OP_APPEND : (r < 55) ? OP_READ : (r < 75) ? OP_FIND : OP_ERASE;
      endcase
      issue_request(op, pick_value(1'b1), pick_index());
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_append_and_lookup();
    test_erase_shifts();
    test_fill_to_capacity();
    test_input_backpressure();
    test_random_traffic(1450);
    drain_list();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bvl_pkg.sv
src/bvl_cell.sv
src/bounded_value_list_unit.sv
bench/tb_bounded_value_list_unit.sv
